[rtl/assert_macros.svh]
// Assertion macros shared by the palette line blitter RTL.
// Each macro expects clk and rst_n to be visible in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define PLBT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define PLBT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/plbt_pkg.sv]
// Package for the palette line blitter: word types, command type and codes.
// No dependencies; used by every module of the block.
package plbt_pkg;

  localparam logic MODE_PALETTE = 1'b0;
  localparam logic MODE_PIXEL   = 1'b1;

  localparam logic [2:0] DISPOSAL_RESTORE_BG = 3'd2;

  localparam logic CFG_IDX_WIDTH  = 1'b0;
  localparam logic CFG_IDX_HEIGHT = 1'b1;

  localparam logic [10:0] WIDTH_RESET  = 11'd320;
  localparam logic [10:0] HEIGHT_RESET = 11'd240;
  localparam logic [10:0] COLUMN_MAX   = 11'd2047;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PW    = 2;
  localparam int QUEUE_CW    = 3;

  typedef struct packed {
    logic        mode;
    logic [7:0]  palette_address;
    logic [15:0] palette_color;
    logic [9:0]  line_x;
    logic [9:0]  line_y;
    logic [7:0]  transparent_index;
    logic [7:0]  background_index;
    logic        has_transparency;
    logic [2:0]  disposal;
    logic [7:0]  pixel_index;
    logic        last_of_line;
  } plbt_in_t;

  typedef struct packed {
    logic [9:0]  screen_x;
    logic [9:0]  screen_y;
    logic [15:0] color;
    logic        new_window;
  } plbt_out_t;

  // Command handed from the front part to the back part.
  typedef struct packed {
    logic        mode;
    logic [7:0]  index;
    logic [15:0] color;
    logic [9:0]  screen_x;
    logic [9:0]  screen_y;
    logic        new_window;
    logic        index_ok;
  } plbt_cmd_t;

endpackage

[rtl/plbt_front.sv]
// Front part: configuration registers, line state and pixel classification.
// Depends on plbt_pkg and assert_macros.svh; pushes commands into plbt_queue.
`include "assert_macros.svh"

module plbt_front import plbt_pkg::*; #(
  parameter int RUN_LIMIT     = 256,
  parameter int PALETTE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [10:0] cfg_wdata,
  input  logic        in_valid,
  input  plbt_in_t    in_data,
  input  logic        q_full,
  output logic        push,
  output plbt_cmd_t   push_cmd
);

  localparam int RUN_W = $clog2(RUN_LIMIT + 1);
  localparam logic [RUN_W-1:0] RUN_LIMIT_V = RUN_W'(RUN_LIMIT);
  localparam logic [8:0] DEPTH_V = 9'(PALETTE_DEPTH);

  logic [10:0]      width_r, height_r;
  logic [10:0]      column_r, column_nxt;
  logic [RUN_W-1:0] run_r, run_nxt;
  logic             in_run_r, in_run_nxt;

  logic        acc;
  logic        keyed;
  logic [7:0]  pix;
  logic [11:0] sx_full;
  logic        drop, skip, emit, nw;

  assign acc = in_valid && !q_full;

  always_comb begin
    keyed = in_data.has_transparency;
    pix   = in_data.pixel_index;
    if (in_data.disposal == DISPOSAL_RESTORE_BG) begin
      if (pix == in_data.transparent_index) begin
        pix = in_data.background_index;
      end
      keyed = 1'b0;
    end
  end

  assign sx_full = {2'b00, in_data.line_x} + {1'b0, column_r};
  assign drop = ({1'b0, in_data.line_y} >= height_r) ||
                ({1'b0, in_data.line_x} >= width_r) ||
                (sx_full >= {1'b0, width_r});
  assign skip = keyed && (pix == in_data.transparent_index);
  assign emit = !drop && !skip;
  assign nw   = keyed ? (!in_run_r || (run_r >= RUN_LIMIT_V)) : !in_run_r;

  always_comb begin
    column_nxt = column_r;
    run_nxt    = run_r;
    in_run_nxt = in_run_r;
    if (acc && in_data.mode == MODE_PIXEL) begin
      if (!drop && skip) begin
        run_nxt    = '0;
        in_run_nxt = 1'b0;
      end
      if (emit) begin
        if (nw) begin
          run_nxt = RUN_W'(1);
        end else if (run_r < RUN_LIMIT_V) begin
          run_nxt = run_r + RUN_W'(1);
        end
        in_run_nxt = 1'b1;
      end
      if (in_data.last_of_line) begin
        column_nxt = '0;
        run_nxt    = '0;
        in_run_nxt = 1'b0;
      end else if (column_r < COLUMN_MAX) begin
        column_nxt = column_r + 11'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
      column_r <= '0;
      run_r    <= '0;
      in_run_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_IDX_WIDTH:  width_r  <= cfg_wdata;
          CFG_IDX_HEIGHT: height_r <= cfg_wdata;
          default: ;
        endcase
      end
      column_r <= column_nxt;
      run_r    <= run_nxt;
      in_run_r <= in_run_nxt;
    end
  end

  // Palette writes outside the palette and pixels that produce nothing never
  // reach the back part.
  always_comb begin
    push = 1'b0;
    if (acc) begin
      if (in_data.mode == MODE_PALETTE) begin
        push = ({1'b0, in_data.palette_address} < DEPTH_V);
      end else begin
        push = emit;
      end
    end
    push_cmd.mode       = in_data.mode;
    push_cmd.index      = (in_data.mode == MODE_PALETTE) ? in_data.palette_address : pix;
    push_cmd.color      = in_data.palette_color;
    push_cmd.screen_x   = sx_full[9:0];
    push_cmd.screen_y   = in_data.line_y;
    push_cmd.new_window = nw;
    push_cmd.index_ok   = ({1'b0, pix} < DEPTH_V);
  end

  `PLBT_ASSERT_NEXT(a_line_end_clears,
    acc && in_data.mode == MODE_PIXEL && in_data.last_of_line,
    column_r == '0 && run_r == '0 && !in_run_r, "line state not cleared after last pixel")
  `PLBT_ASSERT(a_run_bounded, run_r <= RUN_LIMIT_V, "run length above its limit")
  `PLBT_ASSERT(a_run_implies_open, (run_r != '0) == in_run_r,
    "run length and open window disagree")

endmodule

[rtl/plbt_queue.sv]
// Short command queue between the front and back parts of the blitter.
// Depends on plbt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module plbt_queue import plbt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  plbt_cmd_t push_cmd,
  output logic      full,
  input  logic      pop,
  output logic      head_valid,
  output plbt_cmd_t head_cmd
);

  plbt_cmd_t              slot_r [QUEUE_DEPTH];
  logic [QUEUE_PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [QUEUE_CW-1:0]    count_r, count_nxt;

  assign full       = (count_r == QUEUE_CW'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = slot_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + QUEUE_CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QUEUE_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QUEUE_PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QUEUE_PW'(1);
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  `PLBT_ASSERT(a_no_overflow, !(push && full), "push into a full queue")
  `PLBT_ASSERT(a_no_underflow, !(pop && !head_valid), "pop from an empty queue")
  `PLBT_ASSERT(a_count_bound, count_r <= QUEUE_CW'(QUEUE_DEPTH), "queue count out of range")

endmodule

[rtl/plbt_back.sv]
// Back part: palette memory, lookup and the output register stage.
// Depends on plbt_pkg and assert_macros.svh; takes commands from plbt_queue.
`include "assert_macros.svh"

module plbt_back import plbt_pkg::*; #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      head_valid,
  input  plbt_cmd_t head_cmd,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output plbt_out_t out_data
);

  localparam int PAL_AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

  logic [15:0] palette_mem [PALETTE_DEPTH];
  logic [15:0] rd_data_r;
  logic        valid_r;
  logic [9:0]  sx_r, sy_r;
  logic        nw_r, index_ok_r;

  logic advance;
  logic do_write, do_read;

  // The output stage only moves on when it is empty or its word is taken;
  // the memory read register moves with it, so a stalled colour holds.
  assign advance  = !valid_r || !out_stall;
  assign pop      = advance && head_valid;
  assign do_write = pop && (head_cmd.mode == MODE_PALETTE);
  assign do_read  = pop && (head_cmd.mode == MODE_PIXEL);

  always_ff @(posedge clk) begin
    if (do_write) begin
      palette_mem[head_cmd.index[PAL_AW-1:0]] <= head_cmd.color;
    end
    if (do_read) begin
      rd_data_r <= palette_mem[head_cmd.index[PAL_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= do_read;
    end
  end

  always_ff @(posedge clk) begin
    if (do_read) begin
      sx_r       <= head_cmd.screen_x;
      sy_r       <= head_cmd.screen_y;
      nw_r       <= head_cmd.new_window;
      index_ok_r <= head_cmd.index_ok;
    end
  end

  assign out_valid           = valid_r;
  assign out_data.screen_x   = sx_r;
  assign out_data.screen_y   = sy_r;
  assign out_data.color      = index_ok_r ? rd_data_r : 16'd0;
  assign out_data.new_window = nw_r;

  `PLBT_ASSERT(a_pop_only_on_advance, !pop || advance, "command popped while output blocked")
  `PLBT_ASSERT_NEXT(a_read_fills_output, do_read, valid_r, "pixel lookup did not reach output")
  `PLBT_ASSERT_NEXT(a_stall_holds_word, out_valid && out_stall, out_valid,
    "stalled output word dropped")

endmodule

[rtl/palette_line_blitter_transparency_unit.sv]
// Channel | direction | handshake          | word
// in      | input     | in_valid/in_stall  | plbt_in_t: palette write or one pixel
// out     | output    | out_valid/out_stall| plbt_out_t: one display pixel
// cfg     | input     | cfg_we             | cfg_index selects width or height
// One word is accepted per cycle while the four-entry command queue has room.
// A pixel word reaches the output through a queue write, then a registered palette read.
// Sustained rate is one word per cycle while out_stall is low, one command through the back part each cycle.
// Synchronous reset clears line state, queue and output valid; no clearing pass.
// Output stalls back up into the queue and then raise in_stall.
// Top level of the palette line blitter; depends on plbt_pkg and the plbt_* modules.
module palette_line_blitter_transparency_unit import plbt_pkg::*; #(
  parameter int RUN_LIMIT     = 256,
  parameter int PALETTE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [10:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  plbt_in_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output plbt_out_t   out_data
);

  logic      q_full, push, pop, head_valid;
  plbt_cmd_t push_cmd, head_cmd;

  assign in_stall = q_full;

  plbt_front #(
    .RUN_LIMIT    (RUN_LIMIT),
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid (in_valid),
    .in_data  (in_data),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  plbt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (pop),
    .head_valid(head_valid),
    .head_cmd  (head_cmd)
  );

  plbt_back #(
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_valid(head_valid),
    .head_cmd  (head_cmd),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
